FILE: rtl/crbsc_pkg.sv
// Shared types and constants for the constrained-run binary string counter.
`timescale 1ns / 1ps

package crbsc_pkg;

   // Result width and modulus
   localparam int unsigned COUNT_W = 30;
   localparam int unsigned FIELD_W = 10;
   localparam logic [COUNT_W-1:0] MODULUS     = 30'd1000000007;
   localparam logic [31:0]        MODULUS_X2  = 32'd2000000014;

   // Sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_INIT  = 6'b000010,
      ST_SWEEP = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_FINAL = 6'b010000,
      ST_FWAIT = 6'b100000
   } state_type;

   // Controls from the sequencer to the cell unit
   typedef struct packed {
      logic arrive;   // read data (or the trailing zero) lands this cycle
      logic synth;    // trailing zero past column 0 of the row
      logic clear;    // restart the window for a new row
      logic triple;   // mode 1: three-term sum
   } cell_ctrl_type;

endpackage

FILE: rtl/crbsc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module crbsc_ram #(
   parameter int unsigned WIDTH = 30,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/crbsc_cell.sv
// Cell update unit: sliding window of old row values and the modular sum.
`timescale 1ns / 1ps

module crbsc_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  crbsc_pkg::cell_ctrl_type           ctrl,
   input  logic [crbsc_pkg::COUNT_W-1:0]      rd_data,
   output logic                               wr_en,
   output logic [crbsc_pkg::COUNT_W-1:0]      wr_data
);

   logic [1:0]                          fill_ff, fill_in;
   logic [crbsc_pkg::COUNT_W-1:0]       p1_ff, p1_in;
   logic [crbsc_pkg::COUNT_W-1:0]       p2_ff, p2_in;
   logic [crbsc_pkg::COUNT_W-1:0]       cur;
   logic [31:0]                         sum;

   // Newest old value: memory data, or zero left of column 0
   assign cur = ctrl.synth ? '0 : rd_data;

   // p2 is the entry being updated, p1 its left neighbour, cur two to the left
   always_comb begin
      sum = {2'b00, p2_ff} + {2'b00, p1_ff} + (ctrl.triple ? {2'b00, cur} : 32'd0);
      if (sum >= crbsc_pkg::MODULUS_X2) begin
         sum = sum - crbsc_pkg::MODULUS_X2;
      end else if (sum >= {2'b00, crbsc_pkg::MODULUS}) begin
         sum = sum - {2'b00, crbsc_pkg::MODULUS};
      end
   end

   assign wr_en   = ctrl.arrive && (fill_ff == 2'd2);
   assign wr_data = sum[crbsc_pkg::COUNT_W-1:0];

   // Window shift and fill tracking
   always_comb begin
      fill_in = fill_ff;
      p1_in   = p1_ff;
      p2_in   = p2_ff;
      if (ctrl.arrive) begin
         p2_in = p1_ff;
         p1_in = cur;
         if (fill_ff != 2'd2) begin
            fill_in = fill_ff + 2'd1;
         end
      end
      if (ctrl.clear) begin
         fill_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff <= p1_in;
      p2_ff <= p2_in;
   end

endmodule

FILE: rtl/constrained_run_binary_string_count_top.sv
// Top level: request sequencer, line store and cell unit of the string counter.
// Per item, row 0 is set up in the line store, then one sweep runs per zero, one cell
// per cycle through the single read port, and the last entry is read out as the result.
// zeros or ones of zero skip the sweep. Throughput: one item at a time; the next request
// is taken while the previous result waits. Synchronous active-high reset clears the
// sequencer and valid flags; the line store is not cleared.
`timescale 1ns / 1ps

module constrained_run_binary_string_count_top #(
   parameter int unsigned MAX_ONES  = 1023,
   parameter int unsigned MAX_ZEROS = 1023
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_mode,
   input  logic [crbsc_pkg::FIELD_W-1:0]      req_zero_count,
   input  logic [crbsc_pkg::FIELD_W-1:0]      req_one_count,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [crbsc_pkg::COUNT_W-1:0]      rsp_string_count
);

   localparam int unsigned DEPTH = MAX_ONES + 1;
   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned ROW_W = $clog2(MAX_ZEROS + 1);

   crbsc_pkg::state_type              state_ff, state_in;
   logic                              mode_ff, mode_in;
   logic [IDX_W-1:0]                  ones_ff, ones_in;
   logic [ROW_W-1:0]                  rows_ff, rows_in;
   logic [IDX_W-1:0]                  col_ff, col_in;
   logic [IDX_W-1:0]                  wr_j_ff, wr_j_in;
   logic                              done_rd_ff, done_rd_in;
   logic                              arrive_ff, arrive_in;
   logic                              synth_ff, synth_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [crbsc_pkg::COUNT_W-1:0]     rsp_data_ff, rsp_data_in;

   logic                              ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]                  ram_wr_addr, ram_rd_addr;
   logic [crbsc_pkg::COUNT_W-1:0]     ram_wr_data, ram_rd_data;
   logic                              cell_wr_en;
   logic [crbsc_pkg::COUNT_W-1:0]     cell_wr_data;
   crbsc_pkg::cell_ctrl_type          cell_ctrl;
   logic                              init_one;
   logic                              req_xfer;

   assign req_ready = (state_ff == crbsc_pkg::ST_IDLE);
   assign req_xfer  = req_valid && req_ready;

   // Row 0: one within the allowed run length
   assign init_one = (col_ff == IDX_W'(0)) || (col_ff == IDX_W'(1)) ||
                     (mode_ff && (col_ff == IDX_W'(2)));

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      ones_in      = ones_ff;
      rows_in      = rows_ff;
      col_in       = col_ff;
      done_rd_in   = done_rd_ff;
      arrive_in    = 1'b0;
      synth_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = col_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         crbsc_pkg::ST_IDLE: begin
            if (req_xfer) begin
               mode_in = req_mode;
               if (32'(req_one_count) > MAX_ONES) begin
                  ones_in = IDX_W'(MAX_ONES);
               end else begin
                  ones_in = IDX_W'(req_one_count);
               end
               if (32'(req_zero_count) > MAX_ZEROS) begin
                  rows_in = ROW_W'(MAX_ZEROS);
               end else begin
                  rows_in = ROW_W'(req_zero_count);
               end
               col_in   = '0;
               state_in = crbsc_pkg::ST_INIT;
            end
         end
         crbsc_pkg::ST_INIT: begin
            if (col_ff == ones_ff) begin
               if ((rows_ff == '0) || (ones_ff == '0)) begin
                  state_in = crbsc_pkg::ST_FINAL;
               end else begin
                  col_in     = ones_ff;
                  done_rd_in = 1'b0;
                  state_in   = crbsc_pkg::ST_SWEEP;
               end
            end else begin
               col_in = col_ff + IDX_W'(1);
            end
         end
         crbsc_pkg::ST_SWEEP: begin
            arrive_in = 1'b1;
            if (done_rd_ff) begin
               synth_in   = 1'b1;
               done_rd_in = 1'b0;
               state_in   = crbsc_pkg::ST_DRAIN;
            end else begin
               ram_rd_en = 1'b1;
               if (col_ff == '0) begin
                  done_rd_in = 1'b1;
               end else begin
                  col_in = col_ff - IDX_W'(1);
               end
            end
         end
         crbsc_pkg::ST_DRAIN: begin
            rows_in = rows_ff - ROW_W'(1);
            if (rows_ff == ROW_W'(1)) begin
               state_in = crbsc_pkg::ST_FINAL;
            end else begin
               col_in   = ones_ff;
               state_in = crbsc_pkg::ST_SWEEP;
            end
         end
         crbsc_pkg::ST_FINAL: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = ones_ff;
            state_in    = crbsc_pkg::ST_FWAIT;
         end
         crbsc_pkg::ST_FWAIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = ram_rd_data;
               rsp_valid_in = 1'b1;
               state_in     = crbsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = crbsc_pkg::ST_IDLE;
         end
      endcase
   end

   // Write pointer for swept cells, from the right end of each row
   always_comb begin
      wr_j_in = wr_j_ff;
      if ((state_ff == crbsc_pkg::ST_INIT) || (state_ff == crbsc_pkg::ST_DRAIN)) begin
         wr_j_in = ones_ff;
      end else if (cell_wr_en) begin
         wr_j_in = wr_j_ff - IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crbsc_pkg::ST_IDLE;
         done_rd_ff   <= 1'b0;
         arrive_ff    <= 1'b0;
         synth_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         done_rd_ff   <= done_rd_in;
         arrive_ff    <= arrive_in;
         synth_ff     <= synth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      ones_ff     <= ones_in;
      rows_ff     <= rows_in;
      col_ff      <= col_in;
      wr_j_ff     <= wr_j_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Cell unit controls
   assign cell_ctrl.arrive = arrive_ff;
   assign cell_ctrl.synth  = synth_ff;
   assign cell_ctrl.clear  = (state_ff == crbsc_pkg::ST_INIT) ||
                             (state_ff == crbsc_pkg::ST_DRAIN);
   assign cell_ctrl.triple = mode_ff;

   crbsc_cell u_cell (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (cell_ctrl),
      .rd_data (ram_rd_data),
      .wr_en   (cell_wr_en),
      .wr_data (cell_wr_data)
   );

   // Line store write port: row 0 set-up or swept cells
   always_comb begin
      if (state_ff == crbsc_pkg::ST_INIT) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = col_ff;
         ram_wr_data = init_one ? crbsc_pkg::COUNT_W'(1) : '0;
      end else begin
         ram_wr_en   = cell_wr_en;
         ram_wr_addr = wr_j_ff;
         ram_wr_data = cell_wr_data;
      end
   end

   crbsc_ram #(
      .WIDTH (crbsc_pkg::COUNT_W),
      .DEPTH (DEPTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_string_count = rsp_data_ff;

endmodule
